### src/fnsw_pkg.sv
// Shared constants, tables, types and decode functions for the synthesizer word calculator.
package fnsw_pkg;

    localparam int FRACTION_BITS = 18;

    localparam int FREQ_W      = 22;
    localparam int VCO_W       = 23;
    localparam int LADDER_W    = 23;
    localparam int REFCLK_W    = 27;
    localparam int RDIV_W      = 8;
    localparam int GAIN_W      = 5;
    localparam int GAIN_CODE_W = 4;
    localparam int CUTOFF_W    = 5;
    localparam int PCODE_W     = 2;
    localparam int PUMP_W      = 3;
    localparam int INT_W       = 9;
    localparam int CMP_W       = 18;
    localparam int DEN_W       = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = REFCLK_W;

    localparam int QUO_W      = INT_W + FRACTION_BITS;
    localparam int DIV_STAGES = VCO_W + FRACTION_BITS;

    localparam int KHZ_SCALE        = 1000;
    localparam int RESET_REFCLK_VAL = 30000000;
    localparam int RESET_RDIV_VAL   = 2;
    localparam int RESET_GAIN_VAL   = 12;
    localparam int RESET_CMP_VAL    = RESET_REFCLK_VAL / (KHZ_SCALE * RESET_RDIV_VAL);

    localparam logic [REFCLK_W-1:0] RESET_REFCLK = REFCLK_W'(RESET_REFCLK_VAL);
    localparam logic [RDIV_W-1:0]   RESET_RDIV   = RDIV_W'(RESET_RDIV_VAL);
    localparam logic [GAIN_W-1:0]   RESET_GAIN   = GAIN_W'(RESET_GAIN_VAL);
    localparam logic [CMP_W-1:0]    RESET_CMP    = CMP_W'(RESET_CMP_VAL);

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_REFCLK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RDIV   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN   = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_MIN = 22'd250000;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 22'd2150000;
    localparam logic [FREQ_W-1:0] BAND_P2  = 22'd1191000;
    localparam logic [FREQ_W-1:0] BAND_P4  = 22'd596000;
    localparam logic [FREQ_W-1:0] BAND_P8  = 22'd299000;

    localparam logic [PCODE_W-1:0] PCODE_DIV2  = 2'd0;
    localparam logic [PCODE_W-1:0] PCODE_DIV4  = 2'd1;
    localparam logic [PCODE_W-1:0] PCODE_DIV8  = 2'd2;
    localparam logic [PCODE_W-1:0] PCODE_DIV16 = 2'd3;

    localparam int CUTOFF_STEPS = 32;
    localparam int PUMP_STEPS   = 7;

    localparam logic [LADDER_W-1:0] CUTOFF_LADDER [CUTOFF_STEPS] = '{
        23'd6796000, 23'd5828000, 23'd4778000, 23'd4118000,
        23'd3513000, 23'd3136000, 23'd2794000, 23'd2562000,
        23'd2331000, 23'd2169000, 23'd2006000, 23'd1890000,
        23'd1771000, 23'd1680000, 23'd1586000, 23'd1514000,
        23'd1433000, 23'd1374000, 23'd1310000, 23'd1262000,
        23'd1208000, 23'd1167000, 23'd1122000, 23'd1087000,
        23'd1049000, 23'd1018000, 23'd983000,  23'd956000,
        23'd926000,  23'd902000,  23'd875000,  23'd854000
    };

    localparam logic [VCO_W-1:0] PUMP_LIMIT [PUMP_STEPS] = '{
        23'd2380000, 23'd2473000, 23'd2701000, 23'd3022000,
        23'd3388000, 23'd3846000, 23'd4395000
    };

    localparam logic [PUMP_W-1:0] PUMP_CODE [PUMP_STEPS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7
    };

    typedef struct packed {
        logic [CUTOFF_W-1:0] cutoff;
        logic [PCODE_W-1:0]  pcode;
        logic [PUMP_W-1:0]   pump;
    } side_t;

    typedef struct packed {
        logic [CMP_W-1:0] value;
        logic             zero;
    } cmp_t;

    // The ladder descends, so the last threshold above f gives the code.
    function automatic logic [CUTOFF_W-1:0] pick_cutoff(input logic [FREQ_W-1:0] f);
        logic [CUTOFF_W-1:0] code;
        code = '0;
        for (int i = 1; i < CUTOFF_STEPS; i++) begin
            if ({1'b0, f} < CUTOFF_LADDER[i]) begin
                code = CUTOFF_W'(i);
            end
        end
        return code;
    endfunction

    function automatic logic [PUMP_W-1:0] pick_pump(input logic [VCO_W-1:0] vco);
        logic [PUMP_W-1:0] code;
        code = '0;
        for (int i = 0; i < PUMP_STEPS; i++) begin
            if (vco >= PUMP_LIMIT[i]) begin
                code = PUMP_CODE[i];
            end
        end
        return code;
    endfunction

endpackage

### src/fnsw_cfg.sv
// Configuration registers and the iterative divider that forms the comparison frequency.
module fnsw_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fnsw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fnsw_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 busy,
    output fnsw_pkg::cmp_t                       cmp,
    output logic [fnsw_pkg::GAIN_W-1:0]          gain
);

    localparam int COUNT_W = $clog2(fnsw_pkg::REFCLK_W);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(fnsw_pkg::REFCLK_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } state_t;

    state_t                            state_reg;
    logic [fnsw_pkg::REFCLK_W-1:0]     refclk_reg;
    logic [fnsw_pkg::RDIV_W-1:0]       rdiv_reg;
    logic [fnsw_pkg::GAIN_W-1:0]       gain_reg;
    fnsw_pkg::cmp_t                    cmp_reg;
    logic [fnsw_pkg::DEN_W-1:0]        den_reg;
    logic [fnsw_pkg::DEN_W-1:0]        rem_reg;
    logic [fnsw_pkg::REFCLK_W-1:0]     quo_reg;
    logic [COUNT_W-1:0]                count_reg;

    logic [fnsw_pkg::RDIV_W-1:0]       rdiv_eff;
    logic [fnsw_pkg::DEN_W:0]          trial;
    logic                              ge;
    logic [fnsw_pkg::DEN_W-1:0]        rem_next;
    logic [fnsw_pkg::REFCLK_W-1:0]     quo_next;

    // A divider of zero acts as one. The two truncating divisions fold into
    // one division by 1000 * R.
    assign rdiv_eff = (rdiv_reg == '0) ? fnsw_pkg::RDIV_W'(1) : rdiv_reg;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[fnsw_pkg::REFCLK_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? fnsw_pkg::DEN_W'(trial - {1'b0, den_reg})
                      : trial[fnsw_pkg::DEN_W-1:0];
        quo_next = {quo_reg[fnsw_pkg::REFCLK_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            refclk_reg <= fnsw_pkg::RESET_REFCLK;
            rdiv_reg   <= fnsw_pkg::RESET_RDIV;
            gain_reg   <= fnsw_pkg::RESET_GAIN;
            cmp_reg    <= '{value: fnsw_pkg::RESET_CMP, zero: 1'b0};
            den_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            fnsw_pkg::REG_REFCLK: refclk_reg <= cfg_data;
                            fnsw_pkg::REG_RDIV:   rdiv_reg <= cfg_data[fnsw_pkg::RDIV_W-1:0];
                            fnsw_pkg::REG_GAIN:   gain_reg <= cfg_data[fnsw_pkg::GAIN_W-1:0];
                            default: ;
                        endcase
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    den_reg   <= fnsw_pkg::DEN_W'(fnsw_pkg::KHZ_SCALE)
                                 * fnsw_pkg::DEN_W'(rdiv_eff);
                    rem_reg   <= '0;
                    quo_reg   <= refclk_reg;
                    count_reg <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    if (count_reg == COUNT_LAST)
                    begin
                        cmp_reg.value <= quo_next[fnsw_pkg::CMP_W-1:0];
                        cmp_reg.zero  <= (quo_next[fnsw_pkg::CMP_W-1:0] == '0);
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cmp       = cmp_reg;
    assign gain      = gain_reg;

endmodule

### src/fnsw_front.sv
// Front pipeline: clamp, band and cutoff decode, VCO frequency and charge-pump code.
module fnsw_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fnsw_pkg::FREQ_W-1:0]     freq,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fnsw_pkg::VCO_W-1:0]      vco,
    output fnsw_pkg::side_t                 side
);

    logic                           s1_valid_reg;
    logic [fnsw_pkg::FREQ_W-1:0]    s1_freq_reg;
    logic                           s2_valid_reg;
    logic [fnsw_pkg::VCO_W-1:0]     s2_vco_reg;
    logic [fnsw_pkg::CUTOFF_W-1:0]  s2_cutoff_reg;
    logic [fnsw_pkg::PCODE_W-1:0]   s2_pcode_reg;
    logic                           s3_valid_reg;
    logic [fnsw_pkg::VCO_W-1:0]     s3_vco_reg;
    fnsw_pkg::side_t                s3_side_reg;

    logic                           s1_ready;
    logic                           s2_ready;
    logic                           s3_ready;
    logic [fnsw_pkg::FREQ_W-1:0]    s1_freq_next;
    logic [fnsw_pkg::PCODE_W-1:0]   s2_pcode_next;
    logic [fnsw_pkg::VCO_W-1:0]     s2_vco_next;

    // Each stage takes a new request when it is empty or its contents move on.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        if (freq < fnsw_pkg::FREQ_MIN)
        begin
            s1_freq_next = fnsw_pkg::FREQ_MIN;
        end
        else if (freq > fnsw_pkg::FREQ_MAX)
        begin
            s1_freq_next = fnsw_pkg::FREQ_MAX;
        end
        else
        begin
            s1_freq_next = freq;
        end
    end

    always_comb
    begin
        if (s1_freq_reg >= fnsw_pkg::BAND_P2)
        begin
            s2_pcode_next = fnsw_pkg::PCODE_DIV2;
            s2_vco_next   = {s1_freq_reg, 1'b0};
        end
        else if (s1_freq_reg >= fnsw_pkg::BAND_P4)
        begin
            s2_pcode_next = fnsw_pkg::PCODE_DIV4;
            s2_vco_next   = fnsw_pkg::VCO_W'({s1_freq_reg, 2'b0});
        end
        else if (s1_freq_reg >= fnsw_pkg::BAND_P8)
        begin
            s2_pcode_next = fnsw_pkg::PCODE_DIV8;
            s2_vco_next   = fnsw_pkg::VCO_W'({s1_freq_reg, 3'b0});
        end
        else
        begin
            s2_pcode_next = fnsw_pkg::PCODE_DIV16;
            s2_vco_next   = fnsw_pkg::VCO_W'({s1_freq_reg, 4'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_freq_reg <= s1_freq_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_vco_reg    <= s2_vco_next;
            s2_pcode_reg  <= s2_pcode_next;
            s2_cutoff_reg <= fnsw_pkg::pick_cutoff(s1_freq_reg);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_vco_reg         <= s2_vco_reg;
            s3_side_reg.cutoff <= s2_cutoff_reg;
            s3_side_reg.pcode  <= s2_pcode_reg;
            s3_side_reg.pump   <= fnsw_pkg::pick_pump(s2_vco_reg);
        end
    end

    assign out_valid = s3_valid_reg;
    assign vco       = s3_vco_reg;
    assign side      = s3_side_reg;

endmodule

### src/fnsw_div.sv
// Pipelined restoring divider: one quotient bit of (vco << FRACTION_BITS) / cmp per stage.
module fnsw_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fnsw_pkg::VCO_W-1:0]       vco,
    input  fnsw_pkg::side_t                  side_in,
    input  logic [fnsw_pkg::CMP_W-1:0]       cmp,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fnsw_pkg::QUO_W-1:0]       quotient,
    output fnsw_pkg::side_t                  side_out
);

    localparam int NS = fnsw_pkg::DIV_STAGES;

    logic                           valid_reg [NS];
    logic [fnsw_pkg::CMP_W-1:0]     rem_reg   [NS];
    logic [fnsw_pkg::VCO_W-1:0]     vco_reg   [NS];
    logic [fnsw_pkg::QUO_W-1:0]     quo_reg   [NS];
    fnsw_pkg::side_t                side_reg  [NS];
    logic                           rdy       [NS+1];

    assign rdy[NS] = out_ready;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                           prev_valid;
        logic [fnsw_pkg::CMP_W-1:0]     prev_rem;
        logic [fnsw_pkg::VCO_W-1:0]     prev_vco;
        logic [fnsw_pkg::QUO_W-1:0]     prev_quo;
        fnsw_pkg::side_t                prev_side;
        logic                           dbit;
        logic [fnsw_pkg::CMP_W:0]       trial;
        logic                           ge;
        logic [fnsw_pkg::CMP_W-1:0]     rem_next;
        logic [fnsw_pkg::QUO_W-1:0]     quo_next;

        if (k == 0)
        begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = '0;
            assign prev_vco   = vco;
            assign prev_quo   = '0;
            assign prev_side  = side_in;
        end
        else
        begin : g_next
            assign prev_valid = valid_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_vco   = vco_reg[k-1];
            assign prev_quo   = quo_reg[k-1];
            assign prev_side  = side_reg[k-1];
        end

        // The dividend is the VCO word followed by FRACTION_BITS zeros.
        if (k < fnsw_pkg::VCO_W)
        begin : g_vco_bit
            assign dbit = prev_vco[fnsw_pkg::VCO_W-1-k];
        end
        else
        begin : g_zero_bit
            assign dbit = 1'b0;
        end

        assign trial    = {prev_rem, dbit};
        assign ge       = (trial >= {1'b0, cmp});
        assign rem_next = ge ? fnsw_pkg::CMP_W'(trial - {1'b0, cmp})
                             : trial[fnsw_pkg::CMP_W-1:0];
        // Only the low INT_W + FRACTION_BITS quotient bits are kept.
        assign quo_next = {prev_quo[fnsw_pkg::QUO_W-2:0], ge};

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && prev_valid)
            begin
                rem_reg[k]  <= rem_next;
                vco_reg[k]  <= prev_vco;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= prev_side;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NS-1];
    assign quotient  = quo_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

### src/fractional_n_synth_word_calc.sv
// Top level of the fractional-N synthesizer word calculator.
//
//  Channel   Signals                                   Direction  Handshake
//  input     in_valid, in_stall, frequency_khz         in         valid / stall
//  output    out_valid, out_stall, cutoff_code,        out        valid / stall
//            post_divider_code, charge_pump_code,
//            integer_divider, fraction_word, gain_code
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         valid / ready
//
// One request is accepted per cycle while in_stall is low; a request passes through
// three front stages, one divider stage per quotient bit
// (23 + FRACTION_BITS), and the output register.
// A configuration write starts a bit-serial division for the comparison
// frequency; in_stall and the not-ready config port hold until it completes.
// Reset is asynchronous and restores the register defaults; no clearing pass.
// A stalled output only holds back stages that are full, so bubbles close up.
module fractional_n_synth_word_calc (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [fnsw_pkg::FREQ_W-1:0]              frequency_khz,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [fnsw_pkg::CUTOFF_W-1:0]            cutoff_code,
    output logic [fnsw_pkg::PCODE_W-1:0]             post_divider_code,
    output logic [fnsw_pkg::PUMP_W-1:0]              charge_pump_code,
    output logic [fnsw_pkg::INT_W-1:0]               integer_divider,
    output logic [fnsw_pkg::FRACTION_BITS-1:0]       fraction_word,
    output logic [fnsw_pkg::GAIN_CODE_W-1:0]         gain_code,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [fnsw_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [fnsw_pkg::CFG_DATA_W-1:0]          cfg_data
);

    logic                              busy;
    fnsw_pkg::cmp_t                    cmp;
    logic [fnsw_pkg::GAIN_W-1:0]       gain;

    logic                              front_in_ready;
    logic                              front_valid;
    logic                              front_ready;
    logic [fnsw_pkg::VCO_W-1:0]        front_vco;
    fnsw_pkg::side_t                   front_side;

    logic                              div_valid;
    logic                              div_ready;
    logic [fnsw_pkg::QUO_W-1:0]        div_quotient;
    fnsw_pkg::side_t                   div_side;

    logic                              out_valid_reg;
    logic [fnsw_pkg::CUTOFF_W-1:0]     cutoff_reg;
    logic [fnsw_pkg::PCODE_W-1:0]      pcode_reg;
    logic [fnsw_pkg::PUMP_W-1:0]       pump_reg;
    logic [fnsw_pkg::INT_W-1:0]        int_reg;
    logic [fnsw_pkg::FRACTION_BITS-1:0] frac_reg;
    logic [fnsw_pkg::GAIN_CODE_W-1:0]  gain_code_reg;

    fnsw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cmp       (cmp),
        .gain      (gain)
    );

    // Requests wait while the comparison frequency is being recomputed.
    fnsw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && !busy),
        .in_ready  (front_in_ready),
        .freq      (frequency_khz),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .vco       (front_vco),
        .side      (front_side)
    );

    assign in_stall = busy || !front_in_ready;

    fnsw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .vco       (front_vco),
        .side_in   (front_side),
        .cmp       (cmp.value),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quotient  (div_quotient),
        .side_out  (div_side)
    );

    assign div_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            out_valid_reg <= div_valid;
        end
    end

    // A zero comparison frequency forces both divider words to zero.
    always_ff @(posedge clk)
    begin
        if (div_ready && div_valid)
        begin
            cutoff_reg    <= div_side.cutoff;
            pcode_reg     <= div_side.pcode;
            pump_reg      <= div_side.pump;
            int_reg       <= cmp.zero ? '0
                             : div_quotient[fnsw_pkg::QUO_W-1:fnsw_pkg::FRACTION_BITS];
            frac_reg      <= cmp.zero ? '0
                             : div_quotient[fnsw_pkg::FRACTION_BITS-1:0];
            gain_code_reg <= gain[fnsw_pkg::GAIN_W-1:1];
        end
    end

    assign out_valid         = out_valid_reg;
    assign cutoff_code       = cutoff_reg;
    assign post_divider_code = pcode_reg;
    assign charge_pump_code  = pump_reg;
    assign integer_divider   = int_reg;
    assign fraction_word     = frac_reg;
    assign gain_code         = gain_code_reg;

endmodule

### sim/fractional_n_synth_word_calc_test.sv
// Self-checking testbench for the fractional-N synthesizer word calculator.
`timescale 1ns / 1ps

module fractional_n_synth_word_calc_test;
    import fnsw_pkg::*;

    localparam int unsigned FLOOR_KHZ   = 250000;
    localparam int unsigned CEILING_KHZ = 2150000;
    localparam int unsigned DIV2_FROM   = 1191000;
    localparam int unsigned DIV4_FROM   = 596000;
    localparam int unsigned DIV8_FROM   = 299000;
    localparam int          RANDOM_PER_PHASE = 82;
    localparam int          PHASES = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // Descending filter ladder; the code counts the edges after the first that lie above f.
    localparam int unsigned CUTOFF_EDGE [32] = '{
        6796000, 5828000, 4778000, 4118000, 3513000, 3136000, 2794000, 2562000,
        2331000, 2169000, 2006000, 1890000, 1771000, 1680000, 1586000, 1514000,
        1433000, 1374000, 1310000, 1262000, 1208000, 1167000, 1122000, 1087000,
        1049000, 1018000, 983000,  956000,  926000,  902000,  875000,  854000
    };
    localparam int unsigned PUMP_FLOOR [7] = '{
        2380000, 2473000, 2701000, 3022000, 3388000, 3846000, 4395000
    };
    localparam int unsigned PUMP_STEP [7] = '{0, 1, 2, 3, 5, 6, 7};

    typedef struct packed {
        logic [CUTOFF_W-1:0]      cutoff;
        logic [PCODE_W-1:0]       pcode;
        logic [PUMP_W-1:0]        pump;
        logic [INT_W-1:0]         int_div;
        logic [FRACTION_BITS-1:0] frac;
        logic [GAIN_CODE_W-1:0]   gain;
    } tuning_words_t;

    class tuning_word_checker;
        tuning_words_t       pending_words[$];
        int                  errors;
        logic [REFCLK_W-1:0] refclk_hz;
        logic [RDIV_W-1:0]   ref_div;
        logic [GAIN_W-1:0]   gain_db;

        function new();
            errors = 0;
            refclk_hz = RESET_REFCLK;
            ref_div = RESET_RDIV;
            gain_db = RESET_GAIN;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_REFCLK: refclk_hz = data;
                REG_RDIV:   ref_div = data[RDIV_W-1:0];
                REG_GAIN:   gain_db = data[GAIN_W-1:0];
                default:    ;
            endcase
        endfunction

        function tuning_words_t predict_words(logic [FREQ_W-1:0] freq);
            tuning_words_t   w;
            longint unsigned f;
            longint unsigned vco;
            longint unsigned cmp;
            longint unsigned n;
            longint unsigned fr;
            int              shift;
            f = freq;
            if (f < FLOOR_KHZ)
                f = FLOOR_KHZ;
            if (f > CEILING_KHZ)
                f = CEILING_KHZ;
            if (f >= DIV2_FROM)
            begin
                w.pcode = PCODE_DIV2;
                shift = 1;
            end
            else if (f >= DIV4_FROM)
            begin
                w.pcode = PCODE_DIV4;
                shift = 2;
            end
            else if (f >= DIV8_FROM)
            begin
                w.pcode = PCODE_DIV8;
                shift = 3;
            end
            else
            begin
                w.pcode = PCODE_DIV16;
                shift = 4;
            end
            vco = f << shift;
            w.cutoff = '0;
            for (int i = 1; i < 32; i++)
                if (f < CUTOFF_EDGE[i])
                    w.cutoff = w.cutoff + 1'b1;
            w.pump = '0;
            for (int i = 0; i < 7; i++)
                if (vco >= PUMP_FLOOR[i])
                    w.pump = PUMP_W'(PUMP_STEP[i]);
            // A zero divider behaves as one.
            cmp = (longint'(refclk_hz) / 1000) / ((ref_div == 0) ? 1 : longint'(ref_div));
            n = 0;
            fr = 0;
            if (cmp != 0)
            begin
                n = vco / cmp;
                fr = ((vco % cmp) << FRACTION_BITS) / cmp;
            end
            w.int_div = INT_W'(n);
            w.frac = FRACTION_BITS'(fr);
            w.gain = GAIN_CODE_W'(gain_db >> 1);
            return w;
        endfunction

        function void note_request(logic [FREQ_W-1:0] freq);
            pending_words.push_back(predict_words(freq));
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(tuning_words_t got);
            tuning_words_t want;
            if (pending_words.size() == 0)
            begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = pending_words.pop_front();
            if (got.cutoff !== want.cutoff)
                report_mismatch($sformatf("cutoff_code %0d, expected %0d", got.cutoff, want.cutoff));
            if (got.pcode !== want.pcode)
                report_mismatch($sformatf("post_divider_code %0d, expected %0d",
                    got.pcode, want.pcode));
            if (got.pump !== want.pump)
                report_mismatch($sformatf("charge_pump_code %0d, expected %0d", got.pump, want.pump));
            if (got.int_div !== want.int_div)
                report_mismatch($sformatf("integer_divider %0d, expected %0d",
                    got.int_div, want.int_div));
            if (got.frac !== want.frac)
                report_mismatch($sformatf("fraction_word %0d, expected %0d", got.frac, want.frac));
            if (got.gain !== want.gain)
                report_mismatch($sformatf("gain_code %0d, expected %0d", got.gain, want.gain));
        endtask

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [FREQ_W-1:0]        frequency_khz;
    logic                     out_valid;
    logic                     out_stall;
    logic [CUTOFF_W-1:0]      cutoff_code;
    logic [PCODE_W-1:0]       post_divider_code;
    logic [PUMP_W-1:0]        charge_pump_code;
    logic [INT_W-1:0]         integer_divider;
    logic [FRACTION_BITS-1:0] fraction_word;
    logic [GAIN_CODE_W-1:0]   gain_code;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    tuning_word_checker sb;
    bit send_idle;
    bit recv_idle;
    int hold_off;

    fractional_n_synth_word_calc dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .frequency_khz     (frequency_khz),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .cutoff_code       (cutoff_code),
        .post_divider_code (post_divider_code),
        .charge_pump_code  (charge_pump_code),
        .integer_divider   (integer_divider),
        .fraction_word     (fraction_word),
        .gain_code         (gain_code),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(frequency_khz);
        if (rst_n && out_valid && !out_stall)
            sb.check_result({cutoff_code, post_divider_code, charge_pump_code,
                             integer_divider, fraction_word, gain_code});
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            gap = recv_idle ? $urandom_range(0, 14) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_request(input logic [FREQ_W-1:0] freq);
        int gap;
        gap = send_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        frequency_khz <= freq;
        do @(posedge clk); while (in_stall);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no extra edge.
    task automatic program_register(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, data);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [FREQ_W-1:0] random_frequency();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return FREQ_W'($urandom);
        if (pick == 1)
            return FREQ_W'($urandom_range(0, FLOOR_KHZ - 1));
        if (pick == 2)
            return FREQ_W'(CUTOFF_EDGE[$urandom_range(9, 31)] + $urandom_range(0, 2) - 1);
        if (pick == 3)
            return FREQ_W'((PUMP_FLOOR[$urandom_range(0, 6)] >> $urandom_range(1, 4))
                           + $urandom_range(0, 2) - 1);
        return FREQ_W'($urandom_range(FLOOR_KHZ, CEILING_KHZ));
    endfunction

    initial
    begin
        logic [FREQ_W-1:0]     edge_freqs [22];
        logic [REFCLK_W-1:0]   set_refclk [PHASES];
        logic [RDIV_W-1:0]     set_rdiv [PHASES];
        logic [GAIN_W-1:0]     set_gain [PHASES];

        edge_freqs = '{22'd0, 22'h3FFFFF, 22'd249999, 22'd250000, 22'd298999, 22'd299000,
                       22'd595999, 22'd596000, 22'd1190999, 22'd1191000, 22'd2150000,
                       22'd2150001, 22'd853999, 22'd854000, 22'd1098749, 22'd1098750,
                       22'd1510999, 22'd1511000, 22'd2005999, 22'd2006000, 22'd700000,
                       22'd1500000};
        // Phase 0 keeps the reset values; phase 5 is drawn at random.
        set_refclk = '{27'd30000000, 27'd100000000, 27'd1000000, 27'd999,
                       27'h7FFFFFF, 27'd0, 27'd200000, 27'd30000000};
        set_rdiv   = '{8'd2, 8'd1, 8'd255, 8'd7, 8'd0, 8'd0, 8'd255, 8'd2};
        set_gain   = '{5'd12, 5'd30, 5'd0, 5'd31, 5'd1, 5'd0, 5'd2, 5'd12};
        set_refclk[5] = REFCLK_W'($urandom_range(1000000, 100000000));
        set_rdiv[5] = RDIV_W'($urandom_range(1, 255));
        set_gain[5] = GAIN_W'($urandom_range(0, 30));

        sb = new();
        hold_off = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        frequency_khz = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                if (p == 4)
                    program_register(REG_UNUSED, '1);
                program_register(REG_REFCLK, set_refclk[p]);
                program_register(REG_RDIV, CFG_DATA_W'(set_rdiv[p]));
                program_register(REG_GAIN, CFG_DATA_W'(set_gain[p]));
                cfg_valid <= 1'b0;
            end
            send_idle = (p % 3 != 2);
            recv_idle = (p % 4 != 3);
            if (p == 0)
                foreach (edge_freqs[i])
                    send_request(edge_freqs[i]);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                // Back the pipeline up: results held off while requests keep coming.
                if (p == 0 && i == 10)
                begin
                    hold_off = 400;
                    send_idle = 1'b0;
                end
                if (p == 0 && i == 70)
                    send_idle = 1'b1;
                send_request(random_frequency());
            end
            in_valid <= 1'b0;
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
src/fnsw_pkg.sv
src/fnsw_cfg.sv
src/fnsw_front.sv
src/fnsw_div.sv
src/fractional_n_synth_word_calc.sv
sim/fractional_n_synth_word_calc_test.sv
